@@ hw/rtl/rlf_pkg.sv @@
`timescale 1ns / 1ps

package rlf_pkg;

	localparam int AMOUNT_BITS = 31;
	localparam int TAG_FIELD_BITS = 16;
	localparam int COUNT_FIELD_BITS = 7;
	localparam logic [AMOUNT_BITS-1:0] AMOUNT_MAX = {AMOUNT_BITS{1'b1}};

	localparam logic REQ_PUSH = 1'b0;
	localparam logic REQ_POP = 1'b1;

	typedef struct packed {
		logic                      req_type;
		logic [AMOUNT_BITS-1:0]    amount;
		logic [TAG_FIELD_BITS-1:0] tag;
	} req_item_t;

	typedef struct packed {
		logic [AMOUNT_BITS-1:0]      removed;
		logic                        overflow;
		logic                        empty_res;
		logic [TAG_FIELD_BITS-1:0]   front_tag;
		logic [AMOUNT_BITS-1:0]      front_amount;
		logic [COUNT_FIELD_BITS-1:0] run_count;
	} rsp_item_t;

endpackage

@@ hw/rtl/rlf_run_store.sv @@
`timescale 1ns / 1ps

module rlf_run_store #(
	parameter int DEPTH = 64,
	parameter int WIDTH = 47
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// write first in program order, read returns the old word on a collision
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

@@ hw/rtl/run_length_fifo_unit.sv @@
`timescale 1ns / 1ps
// Channel | Handshake            | Payload            | Meaning
// req     | req_valid/req_ready  | req  (req_item_t)  | push or pop request item
// rsp     | rsp_valid/rsp_ready  | rsp  (rsp_item_t)  | queue status after the item
//
// Steps: a push goes from acceptance to a loaded result through read newest,
// update, reread oldest and load. A pop retires whole runs, one run per cycle,
// rereads the oldest run when it shrinks one, then loads; the single read port
// of the run store sets the pace.
// Reset: arst_n clears pointers, run count and handshake state; the run store
// itself is not cleared; entries not holding stored runs are never used.
// Stalls: one result register parts the sides; a new item is taken while the
// previous result still waits, and the sequencer holds only before loading.

module run_length_fifo_unit
	import rlf_pkg::*;
#(
	parameter int RUN_DEPTH = 64,
	parameter int TAG_BITS = 16
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      req_valid,
	output logic      req_ready,
	input  req_item_t req,
	output logic      rsp_valid,
	input  logic      rsp_ready,
	output rsp_item_t rsp
);

	localparam int PW = $clog2(RUN_DEPTH);
	localparam int CW = $clog2(RUN_DEPTH + 1);
	localparam int EW = TAG_BITS + AMOUNT_BITS;
	localparam logic [PW-1:0] LAST_IDX = PW'(RUN_DEPTH - 1);
	localparam logic [CW-1:0] FULL_COUNT = CW'(RUN_DEPTH);

	// sequencer codes
	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_PUSH = 3'd1;
	localparam logic [2:0] ST_POP  = 3'd2;
	localparam logic [2:0] ST_FRD  = 3'd3;
	localparam logic [2:0] ST_DONE = 3'd4;

	logic [2:0]             state_q;
	logic                   op_q;
	logic [AMOUNT_BITS-1:0] amt_q;
	logic [AMOUNT_BITS-1:0] left_q;
	logic [TAG_BITS-1:0]    tag_q;
	logic                   ovf_q;
	logic [PW-1:0]          oldest_q;
	logic [PW-1:0]          newest_q;
	logic [CW-1:0]          count_q;
	logic                   rsp_valid_q;
	rsp_item_t              rsp_q;

	logic                   mem_we;
	logic [PW-1:0]          mem_waddr;
	logic [EW-1:0]          mem_wdata;
	logic [PW-1:0]          mem_raddr;
	logic [EW-1:0]          mem_rdata;

	logic [TAG_BITS-1:0]    rd_tag;
	logic [AMOUNT_BITS-1:0] rd_amt;
	logic [TAG_BITS-1:0]    req_tag;
	logic [TAG_BITS+TAG_FIELD_BITS-1:0]   req_tag_ext;
	logic [TAG_BITS+TAG_FIELD_BITS-1:0]   front_tag_ext;
	logic [CW+COUNT_FIELD_BITS-1:0]       count_ext;
	logic [AMOUNT_BITS:0]   merge_sum;
	logic [AMOUNT_BITS-1:0] merge_amt;
	logic [PW-1:0]          oldest_nx;
	logic [PW-1:0]          newest_nx;
	logic                   req_fire;
	logic                   merge_hit;
	logic                   pop_stop;
	logic                   pop_shrink;
	logic                   load_rsp;

	assign req_ready = (state_q == ST_IDLE);
	assign req_fire  = req_valid && req_ready;
	assign load_rsp  = (state_q == ST_DONE) && (!rsp_valid_q || rsp_ready);

	// keep the low TAG_BITS of the tag field, zero-extend when wider
	assign req_tag_ext = {{TAG_BITS{1'b0}}, req.tag};
	assign req_tag     = req_tag_ext[TAG_BITS-1:0];

	assign rd_tag = mem_rdata[EW-1:AMOUNT_BITS];
	assign rd_amt = mem_rdata[AMOUNT_BITS-1:0];

	assign oldest_nx = (oldest_q == LAST_IDX) ? '0 : oldest_q + PW'(1);
	assign newest_nx = (newest_q == LAST_IDX) ? '0 : newest_q + PW'(1);

	assign merge_hit = (count_q != '0) && (rd_tag == tag_q);
	assign merge_sum = {1'b0, rd_amt} + {1'b0, amt_q};
	assign merge_amt = merge_sum[AMOUNT_BITS] ? AMOUNT_MAX : merge_sum[AMOUNT_BITS-1:0];

	assign pop_stop   = (left_q == '0) || (count_q == '0);
	assign pop_shrink = left_q < rd_amt;

	// read address: newest run for a push, the run after the one being
	// retired during a pop, the oldest run otherwise
	always_comb begin
		priority if (req_fire && (req.req_type == REQ_PUSH)) begin
			mem_raddr = newest_q;
		end else if ((state_q == ST_POP) && !pop_stop && !pop_shrink) begin
			mem_raddr = oldest_nx;
		end else begin
			mem_raddr = oldest_q;
		end
	end

	// write port: merge, or append when not full, on a push; shrink the head on a pop
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = newest_q;
		mem_wdata = {tag_q, merge_amt};
		if (state_q == ST_PUSH) begin
			if (merge_hit) begin
				mem_we = 1'b1;
			end else if (count_q < FULL_COUNT) begin
				mem_we    = 1'b1;
				mem_waddr = (count_q == '0) ? oldest_q : newest_nx;
				mem_wdata = {tag_q, amt_q};
			end
		end else if ((state_q == ST_POP) && !pop_stop && pop_shrink) begin
			mem_we    = 1'b1;
			mem_waddr = oldest_q;
			mem_wdata = {rd_tag, rd_amt - left_q};
		end
	end

	rlf_run_store #(
		.DEPTH(RUN_DEPTH),
		.WIDTH(EW)
	) u_store (
		.clk  (clk),
		.we   (mem_we),
		.waddr(mem_waddr),
		.wdata(mem_wdata),
		.raddr(mem_raddr),
		.rdata(mem_rdata)
	);

	// latch the request payload on acceptance
	always_ff @(posedge clk) begin
		if (req_fire) begin
			op_q  <= req.req_type;
			amt_q <= req.amount;
			tag_q <= req_tag;
		end
	end

	// sequencer and queue pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			oldest_q <= '0;
			newest_q <= '0;
			count_q  <= '0;
			left_q   <= '0;
			ovf_q    <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (req_fire) begin
						left_q  <= req.amount;
						ovf_q   <= 1'b0;
						state_q <= (req.req_type == REQ_PUSH) ? ST_PUSH : ST_POP;
					end
				end
				ST_PUSH: begin
					// merge needs no pointer move; a full store drops the item
					if (!merge_hit) begin
						if (count_q < FULL_COUNT) begin
							newest_q <= (count_q == '0) ? oldest_q : newest_nx;
							count_q  <= count_q + CW'(1);
						end else begin
							ovf_q <= 1'b1;
						end
					end
					state_q <= ST_FRD;
				end
				ST_POP: begin
					priority if (pop_stop) begin
						state_q <= ST_DONE;
					end else if (pop_shrink) begin
						left_q  <= '0;
						state_q <= ST_FRD;
					end else begin
						// retire the whole head run and advance
						left_q   <= left_q - rd_amt;
						oldest_q <= oldest_nx;
						count_q  <= count_q - CW'(1);
					end
				end
				ST_FRD: begin
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (load_rsp) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign front_tag_ext = {{TAG_FIELD_BITS{1'b0}}, rd_tag};
	assign count_ext     = {{COUNT_FIELD_BITS{1'b0}}, count_q};

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (load_rsp) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_rsp) begin
			rsp_q.removed      <= (op_q == REQ_POP) ? amt_q - left_q : '0;
			rsp_q.overflow     <= ovf_q;
			rsp_q.empty_res    <= (count_q == '0);
			rsp_q.front_tag    <= (count_q == '0) ? '0
				: front_tag_ext[TAG_FIELD_BITS-1:0];
			rsp_q.front_amount <= (count_q == '0) ? '0 : rd_amt;
			rsp_q.run_count    <= count_ext[COUNT_FIELD_BITS-1:0];
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

@@ hw/rtl/rlf_checker.sv @@
`timescale 1ns / 1ps

module rlf_checker
	import rlf_pkg::*;
(
	input logic      clk,
	input logic      arst_n,
	input logic      req_valid,
	input logic      req_ready,
	input logic      rsp_valid,
	input logic      rsp_ready,
	input rsp_item_t rsp
);

	// a stalled result holds
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
		else $error("stalled result changed or dropped");

	// one item at a time: no acceptance right after an acceptance
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("request taken while previous item still in progress");

	// empty queue shows no front run and no count
	a_empty_front: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.empty_res |->
			rsp.front_tag == '0 && rsp.front_amount == '0 && rsp.run_count == '0)
		else $error("empty result shows a front run");

	// an overflow only comes from a push, which removes nothing
	a_ovf_push: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.overflow |-> rsp.removed == '0 && !rsp.empty_res)
		else $error("overflow flagged with removal or on empty queue");

endmodule

bind run_length_fifo_unit rlf_checker u_rlf_checker (.*);
